FILE: sv/rpft_pkg.sv
package rpft_pkg;

    localparam int QW        = 16;   // Q1.14 quaternion component
    localparam int PW        = 32;   // Q15.16 position component
    localparam int POSE_W    = 4 * QW + 3 * PW;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Intermediate widths of the datapath
    localparam int QPROD_W   = 2 * QW;          // Q3.28 product
    localparam int QSUM_W    = QPROD_W + 2;     // sum of four products
    localparam int QRND_W    = QSUM_W - 14;
    localparam int C1PROD_W  = QW + PW;         // f * v
    localparam int C1_W      = C1PROD_W + 1;
    localparam int U_W       = C1_W - 14;
    localparam int U2_W      = U_W + 1;
    localparam int C2PROD_W  = QW + U2_W;       // f * 2u
    localparam int C2_W      = C2PROD_W + 2;    // sum of three products
    localparam int R_W       = C2_W - 14;
    localparam int PSUM_W    = R_W + 2;         // shift + v + r

    localparam logic signed [QW-1:0] ROT_W_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_reg_t;

    // Rotation components in the low bits, w first
    typedef struct packed {
        logic signed [PW-1:0] pos_z;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] pos_x;
        logic signed [QW-1:0] rot_z;
        logic signed [QW-1:0] rot_y;
        logic signed [QW-1:0] rot_x;
        logic signed [QW-1:0] rot_w;
    } pose_t;

    function automatic logic signed [QW-1:0] sat_rot(input logic signed [QRND_W-1:0] a);
        logic signed [QW-1:0] res;
        if (a > QRND_W'(32767)) begin
            res = 16'sh7fff;
        end else if (a < -QRND_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = a[QW-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [PSUM_W-1:0] a);
        logic signed [PW-1:0] res;
        logic signed [PSUM_W-1:0] hi;
        logic signed [PSUM_W-1:0] lo;
        hi = PSUM_W'(64'sh7fffffff);
        lo = -PSUM_W'(64'sh80000000);
        if (a > hi) begin
            res = 32'sh7fffffff;
        end else if (a < lo) begin
            res = 32'sh80000000;
        end else begin
            res = a[PW-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/rigid_pose_frame_transform.sv
// Maps a device pose (Q1.14 orientation quaternion, Q15.16 position) from driver space into
// world space with a configured frame rotation quaternion and translation. World orientation
// is the Hamilton product frame * device; world position is shift + v + 2w(f x v) +
// 2f x (f x v), all in exact fixed point with round-half-up at each 2^-14 rescale and
// saturation at the outputs. The quaternions are not normalized. The block takes one item
// per clock unless m_tready stalls the output; an item passes through five register stages
// (device products, rounding of f x v, second products, rounding of the rotated offset,
// final add and saturate). Frame registers are written through the cfg port, which is always
// ready, and must only change while no item is in flight.
module rigid_pose_frame_transform
    import rpft_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // cfg_addr: 0 rot_w, 1 rot_x, 2 rot_y, 3 rot_z, 4 shift_x, 5 shift_y, 6 shift_z
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dev_rot_w, dev_rot_x, dev_rot_y, dev_rot_z, dev_pos_x, dev_pos_y, dev_pos_z
    input  logic [POSE_W-1:0]    s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // world_rot_w, world_rot_x, world_rot_y, world_rot_z, world_pos_x, world_pos_y, world_pos_z
    output logic [POSE_W-1:0]    m_tdata
);

    // frame registers
    logic signed [QW-1:0] rot_reg [4];
    logic signed [PW-1:0] shift_reg [3];

    pose_t in_pose;
    assign in_pose   = pose_t'(s_tdata);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0]   <= ROT_W_RESET;
            rot_reg[1]   <= '0;
            rot_reg[2]   <= '0;
            rot_reg[3]   <= '0;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_addr))
                REG_ROT_W:   rot_reg[0]   <= cfg_wdata[QW-1:0];
                REG_ROT_X:   rot_reg[1]   <= cfg_wdata[QW-1:0];
                REG_ROT_Y:   rot_reg[2]   <= cfg_wdata[QW-1:0];
                REG_ROT_Z:   rot_reg[3]   <= cfg_wdata[QW-1:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_wdata[PW-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_wdata[PW-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, out_vld_reg;
    logic en1, en2, en3, en4, out_en;

    assign out_en   = !out_vld_reg || m_tready;
    assign en4      = !vld4_reg || out_en;
    assign en3      = !vld3_reg || en4;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (en1)    vld1_reg    <= s_tvalid;
            if (en2)    vld2_reg    <= vld1_reg;
            if (en3)    vld3_reg    <= vld2_reg;
            if (en4)    vld4_reg    <= vld3_reg;
            if (out_en) out_vld_reg <= vld4_reg;
        end
    end

    // stage 1: quaternion products frame[i] * device[j] and the products of f x v
    logic signed [QW-1:0]       dq [4];
    logic signed [PW-1:0]       dv [3];
    logic signed [QPROD_W-1:0]  qp_next [4][4];
    logic signed [QPROD_W-1:0]  qp_reg  [4][4];
    logic signed [C1PROD_W-1:0] c1a_next [3];
    logic signed [C1PROD_W-1:0] c1b_next [3];
    logic signed [C1PROD_W-1:0] c1a_reg  [3];
    logic signed [C1PROD_W-1:0] c1b_reg  [3];
    logic signed [PW-1:0]       v1_reg   [3];

    assign dq[0] = in_pose.rot_w;
    assign dq[1] = in_pose.rot_x;
    assign dq[2] = in_pose.rot_y;
    assign dq[3] = in_pose.rot_z;
    assign dv[0] = in_pose.pos_x;
    assign dv[1] = in_pose.pos_y;
    assign dv[2] = in_pose.pos_z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                qp_next[i][j] = QPROD_W'(rot_reg[i]) * QPROD_W'(dq[j]);
            end
        end
        // c1[k] = f[k+1] * v[k+2] - f[k+2] * v[k+1]
        for (int k = 0; k < 3; k++) begin
            c1a_next[k] = C1PROD_W'(rot_reg[1 + (k + 1) % 3]) * C1PROD_W'(dv[(k + 2) % 3]);
            c1b_next[k] = C1PROD_W'(rot_reg[1 + (k + 2) % 3]) * C1PROD_W'(dv[(k + 1) % 3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            qp_reg  <= qp_next;
            c1a_reg <= c1a_next;
            c1b_reg <= c1b_next;
            v1_reg  <= dv;
        end
    end

    // stage 2: Hamilton sums with rounding and saturation; u2 = 2 * round(f x v)
    logic signed [QSUM_W-1:0] qs [4];
    logic signed [QSUM_W-1:0] qr [4];
    logic signed [C1_W-1:0]   c1s [3];
    logic signed [QW-1:0]     q2_next [4];
    logic signed [QW-1:0]     q2_reg  [4];
    logic signed [U2_W-1:0]   u2_next [3];
    logic signed [U2_W-1:0]   u2_reg  [3];
    logic signed [PW-1:0]     v2_reg  [3];

    always_comb begin
        qs[0] = QSUM_W'(qp_reg[0][0]) - QSUM_W'(qp_reg[1][1])
              - QSUM_W'(qp_reg[2][2]) - QSUM_W'(qp_reg[3][3]);
        qs[1] = QSUM_W'(qp_reg[0][1]) + QSUM_W'(qp_reg[1][0])
              + QSUM_W'(qp_reg[2][3]) - QSUM_W'(qp_reg[3][2]);
        qs[2] = QSUM_W'(qp_reg[0][2]) + QSUM_W'(qp_reg[2][0])
              + QSUM_W'(qp_reg[3][1]) - QSUM_W'(qp_reg[1][3]);
        qs[3] = QSUM_W'(qp_reg[0][3]) + QSUM_W'(qp_reg[3][0])
              + QSUM_W'(qp_reg[1][2]) - QSUM_W'(qp_reg[2][1]);
        for (int i = 0; i < 4; i++) begin
            qr[i]      = qs[i] + QSUM_W'(8192);
            q2_next[i] = sat_rot(qr[i][QSUM_W-1:14]);
        end
        for (int k = 0; k < 3; k++) begin
            c1s[k]     = C1_W'(c1a_reg[k]) - C1_W'(c1b_reg[k]) + C1_W'(8192);
            u2_next[k] = {c1s[k][C1_W-1:14], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            q2_reg <= q2_next;
            u2_reg <= u2_next;
            v2_reg <= v1_reg;
        end
    end

    // stage 3: w * u2 and the products of f x u2
    logic signed [C2PROD_W-1:0] wu_next  [3];
    logic signed [C2PROD_W-1:0] c2a_next [3];
    logic signed [C2PROD_W-1:0] c2b_next [3];
    logic signed [C2PROD_W-1:0] wu_reg   [3];
    logic signed [C2PROD_W-1:0] c2a_reg  [3];
    logic signed [C2PROD_W-1:0] c2b_reg  [3];
    logic signed [QW-1:0]       q3_reg   [4];
    logic signed [PW-1:0]       v3_reg   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wu_next[k]  = C2PROD_W'(rot_reg[0]) * C2PROD_W'(u2_reg[k]);
            c2a_next[k] = C2PROD_W'(rot_reg[1 + (k + 1) % 3]) * C2PROD_W'(u2_reg[(k + 2) % 3]);
            c2b_next[k] = C2PROD_W'(rot_reg[1 + (k + 2) % 3]) * C2PROD_W'(u2_reg[(k + 1) % 3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            wu_reg  <= wu_next;
            c2a_reg <= c2a_next;
            c2b_reg <= c2b_next;
            q3_reg  <= q2_reg;
            v3_reg  <= v2_reg;
        end
    end

    // stage 4: round the rotated offset
    logic signed [C2_W-1:0] c2s [3];
    logic signed [R_W-1:0]  r_next [3];
    logic signed [R_W-1:0]  r_reg  [3];
    logic signed [QW-1:0]   q4_reg [4];
    logic signed [PW-1:0]   v4_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c2s[k]    = C2_W'(wu_reg[k]) + C2_W'(c2a_reg[k]) - C2_W'(c2b_reg[k])
                      + C2_W'(8192);
            r_next[k] = c2s[k][C2_W-1:14];
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            r_reg  <= r_next;
            q4_reg <= q3_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 5: add shift and device position, saturate into the output register
    logic signed [PSUM_W-1:0] ps [3];
    pose_t out_next;
    pose_t out_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ps[k] = PSUM_W'(shift_reg[k]) + PSUM_W'(v4_reg[k]) + PSUM_W'(r_reg[k]);
        end
        out_next.rot_w = q4_reg[0];
        out_next.rot_x = q4_reg[1];
        out_next.rot_y = q4_reg[2];
        out_next.rot_z = q4_reg[3];
        out_next.pos_x = sat_pos(ps[0]);
        out_next.pos_y = sat_pos(ps[1]);
        out_next.pos_z = sat_pos(ps[2]);
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule
